// ----- sv/sqm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqm_pkg: shared types and constants
// Sequencer states, CORDIC arctangent table and fixed-point limits.
// ----------------------------------------------------------------------------
package sqm_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_CHECK,
        S_SQR,
        S_SQRT,
        S_CORDIC,
        S_FIN,
        S_DONE
    } t_state;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 31;
    localparam logic [14:0] ANGLE_MAX = 15'd25736;
    localparam logic [36:0] ONE_Q30   = 37'd1 << 30;

    // Arctangent of 2^-i in unsigned Q0.24.
    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/symmetric_quaternion_misorientation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_quaternion_misorientation: symmetry-reduced misorientation angle
// Loads symmetry quaternions into a table and measures 2*acos of the largest
// absolute dot between q1 and q2*s over the loaded entries.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. A load
// transaction (req_type 0) writes one table slot and returns nothing. A
// measure transaction (req_type 1) holds busy high while it works through
// N entries, N being sym_count capped at MAX_SYMMETRIES: each entry passes
// through read, product, accumulate and compare phases on the shared quaternion
// product multipliers and the dot multiplier, then come a check, a squaring
// step, the bit-serial square root, 24 CORDIC iterations, a rounding step and
// a result step. When the dot maximum reaches one, the root and CORDIC are
// skipped. o_done is high for exactly one cycle and flags the result on
// o_angle / o_valid_res; the receiver cannot stall it, so take it then.
// Configuration writes are always ready and take effect at once; write only
// while busy is low. Reading a slot that was never loaded gives undefined
// data.
// ----------------------------------------------------------------------------
module symmetric_quaternion_misorientation #(
    parameter int MAX_SYMMETRIES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [4:0]         i_entry_index,
    input  logic signed [15:0] i_q1_w,
    input  logic signed [15:0] i_q1_x,
    input  logic signed [15:0] i_q1_y,
    input  logic signed [15:0] i_q1_z,
    input  logic signed [15:0] i_q2_w,
    input  logic signed [15:0] i_q2_x,
    input  logic signed [15:0] i_q2_y,
    input  logic signed [15:0] i_q2_z,
    output logic               o_done,
    output logic [14:0]        o_angle,
    output logic               o_valid_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import sqm_pkg::*;

    localparam int AW = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1;
    localparam logic [6:0] MAX_CNT = 7'(MAX_SYMMETRIES);

    // Register indexes
    localparam logic REG_SYM_COUNT = 1'b0;
    localparam logic REG_TOL       = 1'b1;

    t_state r_state, n_state;

    logic [5:0] r_sym_count;
    logic [7:0] r_tol;

    // Symmetry table, {w, x, y, z}
    logic [63:0] r_mem [MAX_SYMMETRIES];
    logic [63:0] r_ent;

    logic signed [15:0] r_q1 [4];
    logic signed [15:0] r_a  [4];

    logic [6:0]  r_cnt;
    logic [6:0]  r_k;
    logic [2:0]  r_ph;
    logic signed [33:0] r_p;
    logic signed [51:0] r_acc;
    logic [36:0] r_best;

    logic [61:0] r_sn, r_sr, r_bit;
    logic [4:0]  r_it;

    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_z;

    logic [14:0] r_angle;
    logic        r_valid;

    logic accept;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // ---- Quaternion product component (four multipliers, shared) ----
    logic [1:0]         pj;
    logic signed [15:0] ma [4];
    logic signed [15:0] mb [4];
    logic [3:0]         mneg;
    logic signed [33:0] p_sum;
    logic signed [15:0] b [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            b[j] = r_ent[63-16*j -: 16];
        end
        pj = 2'(r_ph - 3'd1);
        case (pj)
            2'd0: begin
                ma = '{r_a[0], r_a[1], r_a[2], r_a[3]};
                mb = '{b[0], b[1], b[2], b[3]};
                mneg = 4'b1110;
            end
            2'd1: begin
                ma = '{r_a[1], r_a[0], r_a[3], r_a[2]};
                mb = '{b[0], b[1], b[2], b[3]};
                mneg = 4'b0100;
            end
            2'd2: begin
                ma = '{r_a[2], r_a[3], r_a[0], r_a[1]};
                mb = '{b[0], b[1], b[2], b[3]};
                mneg = 4'b1000;
            end
            default: begin
                ma = '{r_a[3], r_a[2], r_a[1], r_a[0]};
                mb = '{b[0], b[1], b[2], b[3]};
                mneg = 4'b0010;
            end
        endcase
        p_sum = '0;
        for (int j = 0; j < 4; j++) begin
            if (mneg[j]) begin
                p_sum = p_sum - 34'(ma[j] * mb[j]);
            end else begin
                p_sum = p_sum + 34'(ma[j] * mb[j]);
            end
        end
    end

    // ---- Dot term, magnitude and rounding ----
    logic [1:0]         dj;
    logic signed [51:0] dot_term;
    logic [51:0]        mag;
    logic [36:0]        m_val;

    always_comb begin
        dj       = 2'(r_ph - 3'd2);
        dot_term = 52'(r_q1[dj] * r_p);
        mag      = r_acc[51] ? 52'(-r_acc) : 52'(r_acc);
        m_val    = 37'((mag + 52'd16384) >> 15);
    end

    logic last_entry;
    assign last_entry = (r_k + 7'd1) >= r_cnt;

    // ---- Square root and CORDIC steps ----
    logic [61:0]        sq_t;
    logic signed [33:0] dx, dy;
    logic signed [31:0] atan_s;
    logic [26:0]        a_round;

    always_comb begin
        sq_t    = r_sr + r_bit;
        dx      = r_y >>> r_it;
        dy      = r_x >>> r_it;
        atan_s  = 32'($signed({1'b0, atan_q24(r_it)}));
        a_round = r_z[31] ? 27'd0 : 27'(({r_z[25:0], 1'b0} + 27'd1024) >> 11);
    end

    // ---- Next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req_type) begin
                    n_state = S_DOT;
                    // zero count uses no entries
                    if (r_sym_count == 6'd0) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_DOT: begin
                if (r_ph == 3'd6 && last_entry) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_best >= ONE_Q30) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_SQR:    n_state = S_SQRT;
            S_SQRT:   if (r_it == 5'(SQRT_STEPS - 1)) n_state = S_CORDIC;
            S_CORDIC: if (r_it == 5'(CORDIC_STEPS - 1)) n_state = S_FIN;
            S_FIN:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- Outputs ----
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_done      = (r_state == S_DONE);
        o_angle     = r_angle;
        o_valid_res = r_valid;
    end

    // ---- Control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sym_count <= 6'd1;
            r_tol       <= 8'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SYM_COUNT: r_sym_count <= i_cfg_data[5:0];
                    REG_TOL:       r_tol       <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // ---- Table write and registered read ----
    always_ff @(posedge i_clk) begin
        if (accept && !i_req_type && ({2'b00, i_entry_index} < MAX_CNT)) begin
            r_mem[AW'(i_entry_index)] <= {i_q1_w, i_q1_x, i_q1_y, i_q1_z};
        end
        r_ent <= r_mem[r_k[AW-1:0]];
    end

    // ---- Datapath ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q1   <= '{i_q1_w, i_q1_x, i_q1_y, i_q1_z};
                r_a    <= '{i_q2_w, i_q2_x, i_q2_y, i_q2_z};
                r_cnt  <= ({1'b0, r_sym_count} > MAX_CNT) ? MAX_CNT : {1'b0, r_sym_count};
                r_k    <= '0;
                r_ph   <= '0;
                r_acc  <= '0;
                r_best <= '0;
            end
            S_DOT: begin
                // phase 0 reads the entry, 1..4 form p, 2..5 accumulate, 6 compares
                if (r_ph >= 3'd1 && r_ph <= 3'd4) begin
                    r_p <= p_sum;
                end
                if (r_ph >= 3'd2 && r_ph <= 3'd5) begin
                    r_acc <= r_acc + dot_term;
                end
                if (r_ph == 3'd6) begin
                    if (m_val > r_best) begin
                        r_best <= m_val;
                    end
                    r_acc <= '0;
                    r_k   <= r_k + 7'd1;
                    r_ph  <= '0;
                end else begin
                    r_ph <= r_ph + 3'd1;
                end
            end
            S_CHECK: begin
                r_angle <= '0;
                r_valid <= (r_best <= ONE_Q30 + 37'(r_tol));
            end
            S_SQR: begin
                r_sn  <= (62'd1 << 60) - 62'(r_best[29:0] * r_best[29:0]);
                r_sr  <= '0;
                r_bit <= 62'd1 << 60;
                r_it  <= '0;
            end
            S_SQRT: begin
                if (r_sn >= sq_t) begin
                    r_sn <= r_sn - sq_t;
                    r_sr <= (r_sr >> 1) + r_bit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_it == 5'(SQRT_STEPS - 1)) begin
                    r_it <= '0;
                    r_x  <= 34'(r_best[29:0]);
                    r_y  <= 34'((r_sn >= sq_t) ? ((r_sr >> 1) + r_bit) : (r_sr >> 1));
                    r_z  <= '0;
                end else begin
                    r_it <= r_it + 5'd1;
                end
            end
            S_CORDIC: begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_s;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_s;
                end
                r_it <= r_it + 5'd1;
            end
            S_FIN: begin
                r_angle <= (a_round > 27'(ANGLE_MAX)) ? ANGLE_MAX : a_round[14:0];
                r_valid <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule
